// File: hw/rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants and types of the first-fit page allocator: pool size
// default, command codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    // Default number of pages in the pool.
    localparam int NUM_PAGES_DEF = 1024;

    // Command and status codes.
    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_ADD   = 2'd0;
    localparam cmd_t CMD_ALLOC = 2'd1;
    localparam cmd_t CMD_FREE  = 2'd2;

    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_NOFIT   = 2'd1;
    localparam status_t ST_INVALID = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit allocator over a pool of pages. Free marks and block lengths are
// held in two RAMs; a sequencer streams reads and writes over them.
// ----------------------------------------------------------------------------
// Throughput: one command at a time; the page-by-page RAM scan sets the rate.
// Reset: a clearing pass zeroes both RAMs, busy stays high.
// Each result word is shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_allocator #(
    parameter int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire ffpa_pkg::cmd_t                   command,
    input  wire logic [$clog2(NUM_PAGES)-1:0]     page_index,
    input  wire logic [$clog2(NUM_PAGES+1)-1:0]   page_count,
    output logic                                  done,
    output ffpa_pkg::status_t                     status,
    output logic [$clog2(NUM_PAGES)-1:0]          granted_page,
    output logic [$clog2(NUM_PAGES+1)-1:0]        free_count
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int LW = $clog2(NUM_PAGES + 1);
    localparam int SW = LW + 1;

    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);
    localparam logic [SW-1:0] NUM_W     = SW'(NUM_PAGES);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_MARK     = 4'd3;
    localparam logic [3:0] S_ABOVE_RD = 4'd4;
    localparam logic [3:0] S_ABOVE_WT = 4'd5;
    localparam logic [3:0] S_WALK     = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_TAKE     = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0]          state_reg, state_next;
    ffpa_pkg::cmd_t      cmd_reg, cmd_next;
    logic [PW-1:0]       base_reg, base_next;
    logic [LW-1:0]       n_reg, n_next;
    logic [PW-1:0]       last_reg, last_next;
    logic [PW-1:0]       iss_reg, iss_next;
    logic                iss_on_reg, iss_on_next;
    logic                iss_down_reg, iss_down_next;
    logic [PW-1:0]       iss_end_reg, iss_end_next;
    logic                pend_reg, pend_next;
    logic [PW-1:0]       dat_reg, dat_next;
    logic [PW-1:0]       wr_reg, wr_next;
    logic [PW-1:0]       grant_reg, grant_next;
    logic [LW-1:0]       blen_reg, blen_next;
    logic [LW-1:0]       hlen_reg, hlen_next;
    logic [PW-1:0]       fin_addr_reg, fin_addr_next;
    logic [LW-1:0]       fin_len_reg, fin_len_next;
    logic [LW-1:0]       free_total_reg, free_total_next;
    logic                done_reg, done_next;
    ffpa_pkg::status_t   status_reg, status_next;
    logic [PW-1:0]       granted_reg, granted_next;

    // RAM ports.
    logic                fr_we;
    logic [PW-1:0]       fr_waddr;
    logic                fr_wdata;
    logic                fr_rdata;
    logic                len_we;
    logic [PW-1:0]       len_waddr;
    logic [LW-1:0]       len_wdata;
    logic [LW-1:0]       len_rdata;

    // Run ends in widened arithmetic.
    logic [SW-1:0]       idle_end;
    logic [SW-1:0]       hit_end;
    logic [SW-1:0]       take_end;
    logic [LW-1:0]       above_len;
    logic                above_ok;

    // Free-mark store.
    ffpa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_PAGES)
    ) u_free_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (iss_reg),
        .rdata (fr_rdata)
    );

    // Block-length store.
    ffpa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_PAGES)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (iss_reg),
        .rdata (len_rdata)
    );

    assign idle_end  = SW'(page_index) + SW'(page_count);
    assign hit_end   = SW'(dat_reg) + SW'(n_reg);
    assign take_end  = SW'(grant_reg) + SW'(n_reg);
    assign above_ok  = (last_reg != LAST_PAGE);
    assign above_len = (above_ok && fr_rdata) ? (n_reg + len_rdata) : n_reg;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        last_next       = last_reg;
        iss_next        = iss_reg;
        iss_on_next     = iss_on_reg;
        iss_down_next   = iss_down_reg;
        iss_end_next    = iss_end_reg;
        pend_next       = iss_on_reg;
        dat_next        = iss_reg;
        wr_next         = wr_reg;
        grant_next      = grant_reg;
        blen_next       = blen_reg;
        hlen_next       = hlen_reg;
        fin_addr_next   = fin_addr_reg;
        fin_len_next    = fin_len_reg;
        free_total_next = free_total_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        granted_next    = granted_reg;
        fr_we           = 1'b0;
        fr_waddr        = wr_reg;
        fr_wdata        = 1'b0;
        len_we          = 1'b0;
        len_waddr       = wr_reg;
        len_wdata       = '0;

        // Streaming read address: one page per cycle until the end address.
        if (iss_on_reg)
        begin
            if (iss_reg == iss_end_reg)
            begin
                iss_on_next = 1'b0;
            end
            else if (iss_down_reg)
            begin
                iss_next = iss_reg - 1'b1;
            end
            else
            begin
                iss_next = iss_reg + 1'b1;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Zero both stores, one page a cycle.
                fr_we  = 1'b1;
                len_we = 1'b1;
                if (wr_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_next = wr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = command;
                    base_next = page_index;
                    n_next    = page_count;
                    if (command inside {ffpa_pkg::CMD_ADD, ffpa_pkg::CMD_FREE})
                    begin
                        if (page_count == '0 || idle_end > NUM_W)
                        begin
                            done_next    = 1'b1;
                            status_next  = ffpa_pkg::ST_INVALID;
                            granted_next = '0;
                        end
                        else
                        begin
                            last_next     = PW'(idle_end - 1'b1);
                            iss_next      = page_index;
                            iss_end_next  = PW'(idle_end - 1'b1);
                            iss_down_next = 1'b0;
                            iss_on_next   = 1'b1;
                            state_next    = S_CHECK;
                        end
                    end
                    else if (command == ffpa_pkg::CMD_ALLOC)
                    begin
                        if (page_count == '0)
                        begin
                            done_next    = 1'b1;
                            status_next  = ffpa_pkg::ST_INVALID;
                            granted_next = '0;
                        end
                        else if (page_count > free_total_reg)
                        begin
                            done_next    = 1'b1;
                            status_next  = ffpa_pkg::ST_NOFIT;
                            granted_next = '0;
                        end
                        else
                        begin
                            iss_next      = '0;
                            iss_end_next  = LAST_PAGE;
                            iss_down_next = 1'b0;
                            iss_on_next   = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        status_next  = ffpa_pkg::ST_INVALID;
                        granted_next = '0;
                    end
                end
            end

            S_CHECK:
            begin
                // Any page of the run already free makes the request invalid.
                if (pend_reg)
                begin
                    if (fr_rdata)
                    begin
                        iss_on_next  = 1'b0;
                        done_next    = 1'b1;
                        status_next  = ffpa_pkg::ST_INVALID;
                        granted_next = '0;
                        state_next   = S_IDLE;
                    end
                    else if (dat_reg == last_reg)
                    begin
                        iss_on_next = 1'b0;
                        wr_next     = base_reg;
                        state_next  = S_MARK;
                    end
                end
            end

            S_MARK:
            begin
                // Mark each page free with a cleared length.
                fr_we    = 1'b1;
                fr_wdata = 1'b1;
                len_we   = 1'b1;
                if (wr_reg == last_reg)
                begin
                    if (cmd_reg == ffpa_pkg::CMD_ADD)
                    begin
                        fin_addr_next = base_reg;
                        fin_len_next  = n_reg;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        iss_next   = last_reg + 1'b1;
                        state_next = S_ABOVE_RD;
                    end
                end
                else
                begin
                    wr_next = wr_reg + 1'b1;
                end
            end

            S_ABOVE_RD:
            begin
                // The page above the run is being read.
                state_next = S_ABOVE_WT;
            end

            S_ABOVE_WT:
            begin
                // Merge the free block above, then look below.
                hlen_next = above_len;
                if (above_ok && fr_rdata)
                begin
                    len_we    = 1'b1;
                    len_waddr = iss_reg;
                end
                if (base_reg == '0)
                begin
                    fin_addr_next = base_reg;
                    fin_len_next  = above_len;
                    state_next    = S_FIN;
                end
                else
                begin
                    iss_next      = base_reg - 1'b1;
                    iss_end_next  = '0;
                    iss_down_next = 1'b1;
                    iss_on_next   = 1'b1;
                    state_next    = S_WALK;
                end
            end

            S_WALK:
            begin
                // Walk down through free pages to the lower block head.
                if (pend_reg)
                begin
                    if (!fr_rdata)
                    begin
                        iss_on_next   = 1'b0;
                        fin_addr_next = base_reg;
                        fin_len_next  = hlen_reg;
                        state_next    = S_FIN;
                    end
                    else if (len_rdata != '0)
                    begin
                        iss_on_next   = 1'b0;
                        fin_addr_next = dat_reg;
                        fin_len_next  = len_rdata + hlen_reg;
                        state_next    = S_FIN;
                    end
                    else if (dat_reg == '0)
                    begin
                        iss_on_next   = 1'b0;
                        fin_addr_next = base_reg;
                        fin_len_next  = hlen_reg;
                        state_next    = S_FIN;
                    end
                end
            end

            S_SCAN:
            begin
                // First free head whose block covers the request.
                if (pend_reg)
                begin
                    if (fr_rdata && len_rdata >= n_reg)
                    begin
                        iss_on_next = 1'b0;
                        grant_next  = dat_reg;
                        blen_next   = len_rdata;
                        wr_next     = dat_reg;
                        last_next   = (hit_end > NUM_W) ? LAST_PAGE : PW'(hit_end - 1'b1);
                        state_next  = S_TAKE;
                    end
                    else if (dat_reg == LAST_PAGE)
                    begin
                        iss_on_next  = 1'b0;
                        done_next    = 1'b1;
                        status_next  = ffpa_pkg::ST_NOFIT;
                        granted_next = '0;
                        state_next   = S_IDLE;
                    end
                end
            end

            S_TAKE:
            begin
                // Reserve the granted pages and clear their lengths.
                fr_we  = 1'b1;
                len_we = 1'b1;
                if (wr_reg == last_reg)
                begin
                    if (blen_reg > n_reg && take_end < NUM_W)
                    begin
                        fin_addr_next = PW'(take_end);
                        fin_len_next  = blen_reg - n_reg;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        status_next     = ffpa_pkg::ST_DONE;
                        granted_next    = grant_reg;
                        free_total_next = free_total_reg - n_reg;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    wr_next = wr_reg + 1'b1;
                end
            end

            S_FIN:
            begin
                // Write the final head length and report.
                len_we      = 1'b1;
                len_waddr   = fin_addr_reg;
                len_wdata   = fin_len_reg;
                done_next   = 1'b1;
                status_next = ffpa_pkg::ST_DONE;
                state_next  = S_IDLE;
                if (cmd_reg == ffpa_pkg::CMD_ALLOC)
                begin
                    granted_next    = grant_reg;
                    free_total_next = free_total_reg - n_reg;
                end
                else
                begin
                    granted_next    = '0;
                    free_total_next = free_total_reg + n_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            wr_reg         <= '0;
            iss_on_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            free_total_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_reg         <= wr_next;
            iss_on_reg     <= iss_on_next;
            pend_reg       <= pend_next;
            free_total_reg <= free_total_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        base_reg     <= base_next;
        n_reg        <= n_next;
        last_reg     <= last_next;
        iss_reg      <= iss_next;
        iss_down_reg <= iss_down_next;
        iss_end_reg  <= iss_end_next;
        dat_reg      <= dat_next;
        grant_reg    <= grant_next;
        blen_reg     <= blen_next;
        hlen_reg     <= hlen_next;
        fin_addr_reg <= fin_addr_next;
        fin_len_reg  <= fin_len_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_page = granted_reg;
    assign free_count   = free_total_reg;

endmodule

`default_nettype wire

// File: verif/first_fit_page_allocator_test.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator_test
// Self-checking bench for the first-fit page allocator. A short directed
// table covers the extremes, every command and each error case. Random
// traffic follows: allocations, frees of granted runs, region adds, and
// some noise, under several sender idle rates. Every accepted word is run
// through a behavioral model of the page pool, and each reply word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_page_allocator_test;

    localparam int NUM_PAGES = ffpa_pkg::NUM_PAGES_DEF;
    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int LIMIT_CYCLES = 6000000;
    localparam int TAIL_CYCLES = 4 * NUM_PAGES;
    localparam int PHASE_ITEMS = 185;
    localparam int DIRECTED_ROWS = 26;

    // The one command code the package leaves unnamed.
    localparam ffpa_pkg::cmd_t CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        ffpa_pkg::status_t status;
        logic [IDX_W-1:0]  granted;
        logic [CNT_W-1:0]  free_count;
    } reply_t;

    typedef struct packed {
        ffpa_pkg::cmd_t   cmd;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        logic             typed;
        reply_t           want;
    } stim_row_t;

    typedef struct {
        int unsigned base;
        int unsigned cnt;
    } held_run_t;

    // Directed rows; replies are typed in where they are plain to see.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd1, 1'b1, '{ffpa_pkg::ST_NOFIT, 10'd0, 11'd0}},
        '{CMD_UNKNOWN, 10'd1023, 11'd2047, 1'b1, '{ffpa_pkg::ST_INVALID, 10'd0, 11'd0}},
        '{ffpa_pkg::CMD_ADD, 10'd0, 11'd0, 1'b1, '{ffpa_pkg::ST_INVALID, 10'd0, 11'd0}},
        '{ffpa_pkg::CMD_ADD, 10'd1023, 11'd2, 1'b1, '{ffpa_pkg::ST_INVALID, 10'd0, 11'd0}},
        '{ffpa_pkg::CMD_ADD, 10'd0, 11'd2047, 1'b1, '{ffpa_pkg::ST_INVALID, 10'd0, 11'd0}},
        '{ffpa_pkg::CMD_ADD, 10'd0, 11'd1024, 1'b1, '{ffpa_pkg::ST_DONE, 10'd0, 11'd1024}},
        '{ffpa_pkg::CMD_ADD, 10'd5, 11'd1, 1'b1, '{ffpa_pkg::ST_INVALID, 10'd0, 11'd1024}},
        '{ffpa_pkg::CMD_FREE, 10'd1023, 11'd1, 1'b1,
          '{ffpa_pkg::ST_INVALID, 10'd0, 11'd1024}},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd2047, 1'b1,
          '{ffpa_pkg::ST_NOFIT, 10'd0, 11'd1024}},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd1024, 1'b1, '{ffpa_pkg::ST_DONE, 10'd0, 11'd0}},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd1, 1'b1, '{ffpa_pkg::ST_NOFIT, 10'd0, 11'd0}},
        '{ffpa_pkg::CMD_FREE, 10'd0, 11'd1024, 1'b1, '{ffpa_pkg::ST_DONE, 10'd0, 11'd1024}},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd100, 1'b1, '{ffpa_pkg::ST_DONE, 10'd0, 11'd924}},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd200, 1'b1,
          '{ffpa_pkg::ST_DONE, 10'd100, 11'd724}},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd50, 1'b1, '{ffpa_pkg::ST_DONE, 10'd300, 11'd674}},
        '{ffpa_pkg::CMD_FREE, 10'd100, 11'd200, 1'b0, '0},
        '{ffpa_pkg::CMD_FREE, 10'd300, 11'd50, 1'b0, '0},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd924, 1'b0, '0},
        '{ffpa_pkg::CMD_FREE, 10'd1023, 11'd1, 1'b0, '0},
        '{ffpa_pkg::CMD_FREE, 10'd0, 11'd1, 1'b0, '0},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd2, 1'b0, '0},
        '{ffpa_pkg::CMD_FREE, 10'd1, 11'd1022, 1'b0, '0},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd0, 1'b1,
          '{ffpa_pkg::ST_INVALID, 10'd0, 11'd1024}},
        '{ffpa_pkg::CMD_FREE, 10'd1000, 11'd100, 1'b1,
          '{ffpa_pkg::ST_INVALID, 10'd0, 11'd1024}},
        '{ffpa_pkg::CMD_ALLOC, 10'd0, 11'd1, 1'b0, '0},
        '{ffpa_pkg::CMD_FREE, 10'd512, 11'd0, 1'b1,
          '{ffpa_pkg::ST_INVALID, 10'd0, 11'd1023}}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    ffpa_pkg::cmd_t    command = ffpa_pkg::CMD_ADD;
    logic [IDX_W-1:0]  page_index = '0;
    logic [CNT_W-1:0]  page_count = '0;
    logic              done;
    ffpa_pkg::status_t status;
    logic [IDX_W-1:0]  granted_page;
    logic [CNT_W-1:0]  free_count;

    // Model of the page pool.
    bit          page_free [NUM_PAGES];
    int unsigned blk_len [NUM_PAGES];
    int unsigned free_cnt;

    reply_t      pending_replies [$];
    held_run_t   held_runs [$];
    int          idle_pct;
    int          mismatch_count;
    int          cycle_count;

    first_fit_page_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .page_index   (page_index),
        .page_count   (page_count),
        .done         (done),
        .status       (status),
        .granted_page (granted_page),
        .free_count   (free_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A run may be freed or added only if it fits the pool and no page in it
    // is free already.
    function automatic bit run_reserved(int unsigned base, int unsigned n);
        bit ok;
        ok = (n != 0) && (base < NUM_PAGES) && (n <= NUM_PAGES - base);
        for (int unsigned i = base; ok && i < base + n; i++)
        begin
            if (page_free[i])
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic void release_run(int unsigned base, int unsigned n);
        for (int unsigned i = base; i < base + n; i++)
        begin
            page_free[i] = 1'b1;
            blk_len[i] = 0;
        end
        blk_len[base] = n;
        free_cnt += n;
    endfunction

    // Applies one command word to the pool model and returns its reply.
    function automatic reply_t apply_command(ffpa_pkg::cmd_t cmd, int unsigned idx,
                                             int unsigned cnt);
        reply_t      r;
        bit          hit;
        int unsigned len;
        int unsigned j;
        r.status = ffpa_pkg::ST_INVALID;
        r.granted = '0;
        hit = 1'b0;
        case (cmd)
            ffpa_pkg::CMD_ADD:
            begin
                if (run_reserved(idx, cnt))
                begin
                    release_run(idx, cnt);
                    r.status = ffpa_pkg::ST_DONE;
                end
            end
            ffpa_pkg::CMD_ALLOC:
            begin
                if (cnt == 0)
                begin
                    r.status = ffpa_pkg::ST_INVALID;
                end
                else
                begin
                    r.status = ffpa_pkg::ST_NOFIT;
                    // First fit: lowest free head whose block covers the request.
                    for (int unsigned i = 0; cnt <= free_cnt && !hit && i < NUM_PAGES; i++)
                    begin
                        if (page_free[i] && blk_len[i] >= cnt)
                        begin
                            hit = 1'b1;
                            len = blk_len[i];
                            for (int unsigned k = i; k < i + cnt && k < NUM_PAGES; k++)
                            begin
                                page_free[k] = 1'b0;
                                blk_len[k] = 0;
                            end
                            if (len > cnt && i + cnt < NUM_PAGES)
                            begin
                                blk_len[i + cnt] = len - cnt;
                            end
                            free_cnt -= cnt;
                            r.granted = i[IDX_W-1:0];
                            r.status = ffpa_pkg::ST_DONE;
                        end
                    end
                end
            end
            ffpa_pkg::CMD_FREE:
            begin
                if (run_reserved(idx, cnt))
                begin
                    release_run(idx, cnt);
                    r.status = ffpa_pkg::ST_DONE;
                    // Join the free block just above.
                    if (idx + cnt < NUM_PAGES && page_free[idx + cnt])
                    begin
                        blk_len[idx] += blk_len[idx + cnt];
                        blk_len[idx + cnt] = 0;
                    end
                    // Walk down to the head of the free block just below.
                    j = idx;
                    while (!hit && j > 0 && page_free[j - 1])
                    begin
                        j--;
                        if (blk_len[j] != 0)
                        begin
                            blk_len[j] += blk_len[idx];
                            blk_len[idx] = 0;
                            hit = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.free_count = free_cnt[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR: %s", msg);
    endtask

    // Presents one command word, waits for it to be taken, and queues the
    // reply that it must produce.
    task automatic send_word(input ffpa_pkg::cmd_t cmd, input int unsigned idx,
                             input int unsigned cnt, input bit typed,
                             input reply_t typed_reply);
        reply_t    predicted;
        held_run_t run;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        page_index <= idx[IDX_W-1:0];
        page_count <= cnt[CNT_W-1:0];
        do
            @(posedge clk);
        while (busy);
        predicted = apply_command(cmd, idx, cnt);
        pending_replies.push_back(typed ? typed_reply : predicted);
        if (cmd == ffpa_pkg::CMD_ALLOC && predicted.status == ffpa_pkg::ST_DONE)
        begin
            run.base = 32'(predicted.granted);
            run.cnt = cnt;
            held_runs.push_back(run);
        end
    endtask

    // Stops sending until every outstanding reply has come back.
    task automatic hold_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
    endtask

    // Reply checker: each strobed word against the oldest prediction.
    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch($sformatf("reply word with none expected, status %0d", status));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                begin
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              status, want.status));
                end
                if (granted_page !== want.granted)
                begin
                    report_mismatch($sformatf("granted_page got %0d, expected %0d",
                                              granted_page, want.granted));
                end
                if (free_count !== want.free_count)
                begin
                    report_mismatch($sformatf("free_count got %0d, expected %0d",
                                              free_count, want.free_count));
                end
            end
        end
    end

    // Watchdog on total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int             idle_plan [3];
        int unsigned    pick;
        int unsigned    sel;
        int unsigned    idx;
        int unsigned    cnt;
        ffpa_pkg::cmd_t cmd;
        held_run_t      run;
        idle_plan = '{0, 77, 28};
        mismatch_count = 0;
        idle_pct = 0;
        free_cnt = 0;
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            page_free[i] = 1'b0;
            blk_len[i] = 0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        foreach (DIRECTED[i])
        begin
            send_word(DIRECTED[i].cmd, DIRECTED[i].idx, DIRECTED[i].cnt,
                      DIRECTED[i].typed, DIRECTED[i].want);
        end
        hold_until_drained();

        // Random traffic, one phase per sender idle rate.
        foreach (idle_plan[p])
        begin
            idle_pct = idle_plan[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                idx = $urandom_range(NUM_PAGES - 1);
                if (pick < 30 || (pick < 60 && held_runs.size() == 0))
                begin
                    // Allocate, mostly small requests.
                    cmd = ffpa_pkg::CMD_ALLOC;
                    cnt = ($urandom_range(7) == 0) ? $urandom_range(NUM_PAGES, 1)
                                                   : $urandom_range(16, 1);
                end
                else if (pick < 60)
                begin
                    // Give back a granted run, whole or its leading part.
                    sel = $urandom_range(held_runs.size() - 1);
                    run = held_runs[sel];
                    cmd = ffpa_pkg::CMD_FREE;
                    idx = run.base;
                    cnt = ($urandom_range(2) == 0) ? $urandom_range(run.cnt, 1) : run.cnt;
                    if (cnt < run.cnt)
                    begin
                        held_runs[sel].base = run.base + cnt;
                        held_runs[sel].cnt = run.cnt - cnt;
                    end
                    else
                    begin
                        held_runs.delete(sel);
                    end
                end
                else if (pick < 80)
                begin
                    cmd = ffpa_pkg::CMD_ADD;
                    cnt = ($urandom_range(7) == 0) ? $urandom_range(NUM_PAGES, 1)
                                                   : $urandom_range(32, 1);
                end
                else if (pick < 90)
                begin
                    // Free an arbitrary short run; may hit free pages.
                    cmd = ffpa_pkg::CMD_FREE;
                    cnt = $urandom_range(8, 1);
                end
                else
                begin
                    // Noise: any command with a zero, wild or overhanging count.
                    cmd = ffpa_pkg::cmd_t'($urandom_range(3));
                    case ($urandom_range(2))
                        0: cnt = 0;
                        1: cnt = $urandom_range(CNT_MAX);
                        default: cnt = NUM_PAGES - idx + $urandom_range(8, 1);
                    endcase
                end
                send_word(cmd, idx, cnt, 1'b0, '0);
                if ($urandom_range(59) == 0)
                begin
                    hold_until_drained();
                end
            end
            hold_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
